### rtl/tcsp_pkg.sv
// tcsp_pkg: types, constants and helpers shared by the triangle cull/shade/project block
// no dependencies; compiled first
`default_nettype none

package tcsp_pkg;

	localparam int VEC_W = 48;
	localparam int COMP_W = 16;
	localparam int CTR_W = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [39:0] SCREEN_SCALE = 40'sd20;
	localparam logic signed [39:0] ROUND_HALF = 40'sd2048;
	localparam logic signed [19:0] CENTROID_DIV = 20'sd3;
	localparam logic [3:0] SHADE_MAX = 4'd9;

	typedef enum logic [1:0] {
		VERDICT_DRAWN  = 2'd0,
		VERDICT_BEHIND = 2'd1,
		VERDICT_AWAY   = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAMERA   = 3'd0,
		CFG_RIGHT    = 3'd1,
		CFG_UP       = 3'd2,
		CFG_FORWARD  = 3'd3,
		CFG_LIGHT    = 3'd4,
		CFG_CENTER_X = 3'd5,
		CFG_CENTER_Y = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [VEC_W-1:0] cam;
		logic [VEC_W-1:0] right;
		logic [VEC_W-1:0] up;
		logic [VEC_W-1:0] fwd;
		logic [VEC_W-1:0] light;
		logic [CTR_W-1:0] cx;
		logic [CTR_W-1:0] cy;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cam: '0, right: '0, up: '0, fwd: '0, light: '0,
		cx: 11'd300, cy: 11'd300
	};

	// handoff from the transform half to the shading half
	typedef struct packed {
		logic [5:0][15:0] screen;   // ax, ay, bx, by, cx, cy
		logic             behind;
		logic [2:0][54:0] en;       // eye offset times normal, per axis
		logic [2:0][54:0] wn;       // light offset times normal, per axis
		logic [2:0][39:0] ww;       // light offset squared, per axis
		logic [2:0][69:0] nn;       // normal squared, per axis
	} xf_t;

	typedef struct packed {
		verdict_t         verdict;
		logic [3:0]       shade;
		logic [5:0][15:0] screen;
	} res_t;

	function automatic logic signed [COMP_W-1:0] vcomp(input logic [VEC_W-1:0] v, input int k);
		return v[COMP_W*k +: COMP_W];
	endfunction

endpackage

`default_nettype wire

### rtl/tcsp_tri_if.sv
// tcsp_tri_if: triangle input channel, valid/ready with three Q8.8 vertices
// standalone, no package needed
`default_nettype none

interface tcsp_tri_if;
	logic valid;
	logic ready;
	logic signed [15:0] a_x, a_y, a_z;
	logic signed [15:0] b_x, b_y, b_z;
	logic signed [15:0] c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

`default_nettype wire

### rtl/tcsp_res_if.sv
// tcsp_res_if: result channel, verdict, shade level and six Q12.4 screen coordinates
// standalone, no package needed
`default_nettype none

interface tcsp_res_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic [3:0] shade_level;
	logic signed [15:0] screen_ax, screen_ay, screen_bx, screen_by, screen_cx, screen_cy;

	modport source (output valid, verdict, shade_level, screen_ax, screen_ay, screen_bx,
		screen_by, screen_cx, screen_cy, input ready);
	modport sink (input valid, verdict, shade_level, screen_ax, screen_ay, screen_bx,
		screen_by, screen_cx, screen_cy, output ready);
endinterface

`default_nettype wire

### rtl/tcsp_xform.sv
// tcsp_xform: stages 1-4, camera-space projection, screen mapping, face normal products
// depends on tcsp_pkg and tcsp_tri_if
`default_nettype none

module tcsp_xform import tcsp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	tcsp_tri_if.sink        tri_in,
	output logic            xf_valid,
	input  logic            xf_ready,
	output xf_t             xf
);

	logic signed [15:0] vin [3][3];
	logic signed [15:0] cam [3];
	logic signed [15:0] rax [3];
	logic signed [15:0] uax [3];
	logic signed [15:0] fax [3];
	logic signed [15:0] lpos [3];

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [16:0] d_c [3][3];
	logic signed [16:0] ab_c [3];
	logic signed [16:0] ac_c [3];
	logic signed [17:0] s_c [3];
	logic signed [19:0] w_c [3];
	logic signed [19:0] e_c [3];

	logic signed [16:0] d_s1 [3][3];
	logic signed [16:0] ab_s1 [3];
	logic signed [16:0] ac_s1 [3];
	logic signed [19:0] w_s1 [3];
	logic signed [19:0] e_s1 [3];

	logic signed [32:0] pr_s2 [3][3];
	logic signed [32:0] pu_s2 [3][3];
	logic signed [32:0] pf_s2 [3][3];
	logic signed [33:0] cp_s2 [6];
	logic signed [19:0] w_s2 [3];
	logic signed [19:0] e_s2 [3];

	logic signed [34:0] tx_s3 [3];
	logic signed [34:0] ty_s3 [3];
	logic signed [34:0] tz_s3 [3];
	logic signed [34:0] n_s3 [3];
	logic signed [19:0] w_s3 [3];
	logic signed [19:0] e_s3 [3];

	xf_t xf_s4;

	function automatic logic signed [15:0] to_screen(input logic signed [39:0] scaled,
			input logic [CTR_W-1:0] ctr);
		logic signed [39:0] rnd;
		logic signed [29:0] sum;
		rnd = (scaled + ROUND_HALF) >>> 12;
		sum = $signed({15'd0, ctr, 4'd0}) + 30'(rnd);
		if (sum > 30'sd32767)
			return 16'sh7fff;
		else if (sum < -30'sd32768)
			return 16'sh8000;
		else
			return 16'(sum);
	endfunction

	always_comb begin
		vin[0][0] = tri_in.a_x; vin[0][1] = tri_in.a_y; vin[0][2] = tri_in.a_z;
		vin[1][0] = tri_in.b_x; vin[1][1] = tri_in.b_y; vin[1][2] = tri_in.b_z;
		vin[2][0] = tri_in.c_x; vin[2][1] = tri_in.c_y; vin[2][2] = tri_in.c_z;
		for (int k = 0; k < 3; k++) begin
			cam[k] = vcomp(cfg.cam, k);
			rax[k] = vcomp(cfg.right, k);
			uax[k] = vcomp(cfg.up, k);
			fax[k] = vcomp(cfg.fwd, k);
			lpos[k] = vcomp(cfg.light, k);
		end
	end

	// stall chain: a stage loads when empty or when the next one moves
	assign en4 = !v_s4 || xf_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign tri_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= tri_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: offsets from camera, edges, centroid-scaled offsets
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++)
				d_c[i][k] = 17'(vin[i][k]) - 17'(cam[k]);
			ab_c[k] = 17'(vin[1][k]) - 17'(vin[0][k]);
			ac_c[k] = 17'(vin[2][k]) - 17'(vin[0][k]);
			s_c[k] = 18'(vin[0][k]) + 18'(vin[1][k]) + 18'(vin[2][k]);
			w_c[k] = 20'(lpos[k]) * CENTROID_DIV - 20'(s_c[k]);
			e_c[k] = 20'(cam[k]) * CENTROID_DIV - 20'(s_c[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			d_s1 <= d_c;
			ab_s1 <= ab_c;
			ac_s1 <= ac_c;
			w_s1 <= w_c;
			e_s1 <= e_c;
		end
	end

	// stage 2: axis products and cross-product terms
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s2[i][k] <= 33'(d_s1[i][k]) * 33'(rax[k]);
					pu_s2[i][k] <= 33'(d_s1[i][k]) * 33'(uax[k]);
					pf_s2[i][k] <= 33'(d_s1[i][k]) * 33'(fax[k]);
				end
			end
			cp_s2[0] <= 34'(ab_s1[1]) * 34'(ac_s1[2]);
			cp_s2[1] <= 34'(ab_s1[2]) * 34'(ac_s1[1]);
			cp_s2[2] <= 34'(ab_s1[2]) * 34'(ac_s1[0]);
			cp_s2[3] <= 34'(ab_s1[0]) * 34'(ac_s1[2]);
			cp_s2[4] <= 34'(ab_s1[0]) * 34'(ac_s1[1]);
			cp_s2[5] <= 34'(ab_s1[1]) * 34'(ac_s1[0]);
			w_s2 <= w_s1;
			e_s2 <= e_s1;
		end
	end

	// stage 3: dot-product sums and the normal
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				tx_s3[i] <= 35'(pr_s2[i][0]) + 35'(pr_s2[i][1]) + 35'(pr_s2[i][2]);
				ty_s3[i] <= 35'(pu_s2[i][0]) + 35'(pu_s2[i][1]) + 35'(pu_s2[i][2]);
				tz_s3[i] <= 35'(pf_s2[i][0]) + 35'(pf_s2[i][1]) + 35'(pf_s2[i][2]);
			end
			for (int k = 0; k < 3; k++)
				n_s3[k] <= 35'(cp_s2[2*k]) - 35'(cp_s2[2*k+1]);
			w_s3 <= w_s2;
			e_s3 <= e_s2;
		end
	end

	// stage 4: screen mapping, depth test, normal products
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int i = 0; i < 3; i++) begin
				xf_s4.screen[2*i] <= to_screen(40'(tx_s3[i]) * SCREEN_SCALE, cfg.cx);
				xf_s4.screen[2*i+1] <= to_screen(40'sd0 - 40'(ty_s3[i]) * SCREEN_SCALE,
					cfg.cy);
			end
			xf_s4.behind <= tz_s3[0][34] | tz_s3[1][34] | tz_s3[2][34];
			for (int k = 0; k < 3; k++) begin
				xf_s4.en[k] <= 55'(e_s3[k]) * 55'(n_s3[k]);
				xf_s4.wn[k] <= 55'(w_s3[k]) * 55'(n_s3[k]);
				xf_s4.ww[k] <= 40'(w_s3[k]) * 40'(w_s3[k]);
				xf_s4.nn[k] <= 70'(n_s3[k]) * 70'(n_s3[k]);
			end
		end
	end

	assign xf_valid = v_s4;
	assign xf = xf_s4;

endmodule

`default_nettype wire

### rtl/tcsp_shade.sv
// tcsp_shade: stages 5-9, cull verdict and exact Lambert shade quantization, result register
// depends on tcsp_pkg
`default_nettype none

module tcsp_shade import tcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic xf_valid,
	output logic xf_ready,
	input  xf_t  xf,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic en5, en6, en7, en8, en9;
	logic v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [56:0] face_c;
	logic signed [56:0] dd_c;
	logic [41:0] ww_c;
	logic [71:0] nn_c;
	verdict_t verdict_c;

	verdict_t verdict_s5, verdict_s6, verdict_s7, verdict_s8;
	logic ok_s5, ok_s6, ok_s7, ok_s8;
	logic [5:0][15:0] scr_s5, scr_s6, scr_s7, scr_s8;
	logic [55:0] dd_s5;
	logic [41:0] ww_s5;
	logic [71:0] nn_s5;

	logic [55:0] hh_s6, hl_s6, ll_s6;
	logic [44:0] pw_s6 [3][2];

	logic [111:0] dsq_s7;
	logic [113:0] prod_s7;
	logic [113:0] prod_c;

	logic [118:0] lhs_s8;
	logic [120:0] thr_s8 [9];

	logic [3:0] shade_c;
	res_t res_s9;

	assign en9 = !v_s9 || res_ready;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign xf_ready = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en5) v_s5 <= xf_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// stage 5: sums of products and the cull decision
	always_comb begin
		face_c = 57'($signed(xf.en[0])) + 57'($signed(xf.en[1])) + 57'($signed(xf.en[2]));
		dd_c = 57'($signed(xf.wn[0])) + 57'($signed(xf.wn[1])) + 57'($signed(xf.wn[2]));
		ww_c = 42'(xf.ww[0]) + 42'(xf.ww[1]) + 42'(xf.ww[2]);
		nn_c = 72'(xf.nn[0]) + 72'(xf.nn[1]) + 72'(xf.nn[2]);
		if (xf.behind)
			verdict_c = VERDICT_BEHIND;
		else if (face_c[56])
			verdict_c = VERDICT_AWAY;
		else
			verdict_c = VERDICT_DRAWN;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			verdict_s5 <= verdict_c;
			ok_s5 <= (verdict_c == VERDICT_DRAWN) && (ww_c != '0) && (nn_c != '0)
				&& !dd_c[56] && (dd_c != '0);
			dd_s5 <= dd_c[55:0];
			ww_s5 <= ww_c;
			nn_s5 <= nn_c;
			scr_s5 <= xf.screen;
		end
	end

	// stage 6: partial products of dd^2 and nn*ww
	always_ff @(posedge clk) begin
		if (en6) begin
			hh_s6 <= 56'(dd_s5[55:28]) * 56'(dd_s5[55:28]);
			hl_s6 <= 56'(dd_s5[55:28]) * 56'(dd_s5[27:0]);
			ll_s6 <= 56'(dd_s5[27:0]) * 56'(dd_s5[27:0]);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 2; j++)
					pw_s6[i][j] <= 45'(nn_s5[24*i +: 24]) * 45'(ww_s5[21*j +: 21]);
			verdict_s6 <= verdict_s5;
			ok_s6 <= ok_s5;
			scr_s6 <= scr_s5;
		end
	end

	// stage 7: recombine partial products
	always_comb begin
		prod_c = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 2; j++)
				prod_c = prod_c + (114'(pw_s6[i][j]) << (24*i + 21*j));
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			dsq_s7 <= (112'(hh_s6) << 56) + (112'(hl_s6) << 29) + 112'(ll_s6);
			prod_s7 <= prod_c;
			verdict_s7 <= verdict_s6;
			ok_s7 <= ok_s6;
			scr_s7 <= scr_s6;
		end
	end

	// stage 8: 100*dd^2 and the k^2 thresholds
	always_ff @(posedge clk) begin
		if (en8) begin
			lhs_s8 <= (119'(dsq_s7) << 6) + (119'(dsq_s7) << 5) + (119'(dsq_s7) << 2);
			for (int k = 0; k < 9; k++)
				thr_s8[k] <= 121'(prod_s7) * 121'((k + 1) * (k + 1));
			verdict_s8 <= verdict_s7;
			ok_s8 <= ok_s7;
			scr_s8 <= scr_s7;
		end
	end

	// stage 9: pick the largest level whose threshold is met
	always_comb begin
		shade_c = '0;
		if (ok_s8) begin
			for (int k = 0; k < 9; k++)
				if (121'(lhs_s8) >= thr_s8[k])
					shade_c = 4'(k + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en9) begin
			res_s9.verdict <= verdict_s8;
			res_s9.shade <= shade_c;
			res_s9.screen <= scr_s8;
		end
	end

	assign res_valid = v_s9;
	assign res = res_s9;

endmodule

`default_nettype wire

### rtl/triangle_cull_shade_project_top.sv
// triangle_cull_shade_project_top: config registers, transform and shading pipelines
// depends on tcsp_pkg, tcsp_tri_if, tcsp_res_if, tcsp_xform, tcsp_shade
`default_nettype none

// One triangle word per clock in, one result word per clock out while the result side is
// ready; an accepted triangle passes through the register stages into the result register.
// The nine register stages are: camera offsets, edges and centroid offsets,
// axis and cross products, dot sums, screen mapping with depth test, cull decision,
// split 56x56 and 72x42 partial products, their recombination, the scaled shade
// thresholds, and the threshold compare into the output register. Every stage holds
// its word under back-pressure and empty stages fill, so a waiting result does not
// stop new triangles until the pipe is full. Registers are written through the plain
// write port and must only change while no triangle is in flight.
module triangle_cull_shade_project_top import tcsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VEC_W-1:0]     cfg_data,
	tcsp_tri_if.sink             tri_in,
	tcsp_res_if.source           res_out
);

	cfg_t cfg_q;
	xf_t xf;
	logic xf_valid, xf_ready;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CAMERA:   cfg_q.cam <= cfg_data;
				CFG_RIGHT:    cfg_q.right <= cfg_data;
				CFG_UP:       cfg_q.up <= cfg_data;
				CFG_FORWARD:  cfg_q.fwd <= cfg_data;
				CFG_LIGHT:    cfg_q.light <= cfg_data;
				CFG_CENTER_X: cfg_q.cx <= cfg_data[CTR_W-1:0];
				CFG_CENTER_Y: cfg_q.cy <= cfg_data[CTR_W-1:0];
				default: ;
			endcase
		end
	end

	tcsp_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.tri_in   (tri_in),
		.xf_valid (xf_valid),
		.xf_ready (xf_ready),
		.xf       (xf)
	);

	tcsp_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.xf_valid  (xf_valid),
		.xf_ready  (xf_ready),
		.xf        (xf),
		.res_valid (res_out.valid),
		.res_ready (res_out.ready),
		.res       (res)
	);

	assign res_out.verdict = res.verdict;
	assign res_out.shade_level = res.shade;
	assign res_out.screen_ax = res.screen[0];
	assign res_out.screen_ay = res.screen[1];
	assign res_out.screen_bx = res.screen[2];
	assign res_out.screen_by = res.screen[3];
	assign res_out.screen_cx = res.screen[4];
	assign res_out.screen_cy = res.screen[5];

`ifndef SYNTHESIS
	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> res_out.shade_level <= SHADE_MAX)
		else $error("shade level above top step");

	a_culled_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.verdict != VERDICT_DRAWN) |-> res_out.shade_level == 4'd0)
		else $error("culled triangle carries a shade");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!res_out.valid |-> tri_in.ready)
		else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire
